// ----- rtl/core/maxr_pkg.sv -----
package maxr_pkg;

  localparam int MAX_FREE = 64;
  localparam int COORD_BITS = 15;
  localparam int WORK_DEPTH = 5 * MAX_FREE;
  localparam int FREE_AW = $clog2(MAX_FREE);
  localparam int WORK_AW = $clog2(WORK_DEPTH);
  localparam int FCNT_W = $clog2(MAX_FREE + 1);
  localparam int WCNT_W = $clog2(WORK_DEPTH + 1);

  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] REG_ATLAS_W = 2'd0;
  localparam logic [1:0] REG_ATLAS_H = 2'd1;
  localparam logic [1:0] REG_PADDING = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } box_t;

  typedef struct packed {
    logic dead;
    box_t box;
  } work_t;

  typedef struct packed {
    logic new_atlas;
    logic [14:0] rect_width;
    logic [14:0] rect_height;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
  } out_t;

  function automatic logic box_inside(box_t a, box_t b);
    logic [COORD_BITS:0] ar, at, br, bt;
    ar = {1'b0, a.x} + {1'b0, a.w};
    at = {1'b0, a.y} + {1'b0, a.h};
    br = {1'b0, b.x} + {1'b0, b.w};
    bt = {1'b0, b.y} + {1'b0, b.h};
    return (a.x >= b.x) && (a.y >= b.y) && (ar <= br) && (at <= bt);
  endfunction

endpackage

// ----- rtl/core/maxr_ram.sv -----
module maxr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/core/maxr_seq.sv -----
module maxr_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  maxr_pkg::in_t      item,
  input  maxr_pkg::coord_t   atlas_w,
  input  maxr_pkg::coord_t   atlas_h,
  input  logic [7:0]         pad,
  input  logic               res_free,
  output logic               busy,
  output logic               res_load,
  output maxr_pkg::out_t     res
);
  import maxr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FT_RD = 4'd1;
  localparam logic [3:0] S_FT_EV = 4'd2;
  localparam logic [3:0] S_SV_RD = 4'd3;
  localparam logic [3:0] S_SV_EV = 4'd4;
  localparam logic [3:0] S_PC_RD = 4'd5;
  localparam logic [3:0] S_PC_LD = 4'd6;
  localparam logic [3:0] S_PC_K  = 4'd7;
  localparam logic [3:0] S_PI_RD = 4'd8;
  localparam logic [3:0] S_PI_LD = 4'd9;
  localparam logic [3:0] S_PJ_RD = 4'd10;
  localparam logic [3:0] S_PJ_EV = 4'd11;
  localparam logic [3:0] S_CP_CK = 4'd12;
  localparam logic [3:0] S_CP_RD = 4'd13;
  localparam logic [3:0] S_CP_EV = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state;
  logic [FCNT_W-1:0] free_count, fi, m;
  logic [WCNT_W-1:0] pi, pj, wn, drops;
  logic [1:0] k;
  logic [COORD_BITS:0] pw, ph;
  logic found;
  coord_t best_s, best_l, bx, by;
  box_t fcur, wi;

  logic free_we;
  logic [FREE_AW-1:0] free_waddr;
  box_t free_wdata, free_rd, free_unused;
  logic work_we;
  logic [WORK_AW-1:0] work_waddr;
  work_t work_wdata, work_rd_a, work_rd_b;

  maxr_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_FREE)) u_free (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr_a(fi[FREE_AW-1:0]), .rdata_a(free_rd),
    .raddr_b(fi[FREE_AW-1:0]), .rdata_b(free_unused)
  );

  maxr_ram #(.WIDTH($bits(work_t)), .DEPTH(WORK_DEPTH)) u_work (
    .clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
    .raddr_a(pi[WORK_AW-1:0]), .rdata_a(work_rd_a),
    .raddr_b(pj[WORK_AW-1:0]), .rdata_b(work_rd_b)
  );

  logic fits;
  coord_t dw, dh, cs, cl;
  logic [COORD_BITS+1:0] pr, pt, fr, ft;
  logic nonint_rd, nonint_cur;
  logic [COORD_BITS+1:0] cr, ctp;
  logic piece_ok;
  box_t piece;
  logic drop;

  always_comb begin
    fits = ({1'b0, free_rd.w} >= pw) && ({1'b0, free_rd.h} >= ph);
    dw = free_rd.w - pw[COORD_BITS-1:0];
    dh = free_rd.h - ph[COORD_BITS-1:0];
    cs = (dw < dh) ? dw : dh;
    cl = (dw < dh) ? dh : dw;
    pr = {2'b0, bx} + {1'b0, pw};
    pt = {2'b0, by} + {1'b0, ph};
    fr = {2'b0, free_rd.x} + {2'b0, free_rd.w};
    ft = {2'b0, free_rd.y} + {2'b0, free_rd.h};
    nonint_rd = ({2'b0, bx} >= fr) || (pr <= {2'b0, free_rd.x}) ||
                ({2'b0, by} >= ft) || (pt <= {2'b0, free_rd.y});
    cr = {2'b0, fcur.x} + {2'b0, fcur.w};
    ctp = {2'b0, fcur.y} + {2'b0, fcur.h};
    nonint_cur = ({2'b0, bx} >= cr) || (pr <= {2'b0, fcur.x}) ||
                 ({2'b0, by} >= ctp) || (pt <= {2'b0, fcur.y});
    piece = fcur;
    piece_ok = 1'b0;
    case (k)
      2'd0: begin
        piece_ok = bx > fcur.x;
        piece.w = bx - fcur.x;
      end
      2'd1: begin
        piece_ok = pr < cr;
        piece.x = pr[COORD_BITS-1:0];
        piece.w = coord_t'(cr - pr);
      end
      2'd2: begin
        piece_ok = by > fcur.y;
        piece.h = by - fcur.y;
      end
      default: begin
        piece_ok = pt < ctp;
        piece.y = pt[COORD_BITS-1:0];
        piece.h = coord_t'(ctp - pt);
      end
    endcase
    drop = (pj != pi) && !work_rd_b.dead && box_inside(wi, work_rd_b.box);
  end

  always_comb begin
    free_we = 1'b0;
    free_waddr = '0;
    free_wdata = work_rd_a.box;
    work_we = 1'b0;
    work_waddr = wn[WORK_AW-1:0];
    work_wdata = '{dead: 1'b0, box: free_rd};
    unique case (state)
      S_IDLE: begin
        free_we = start && item.new_atlas;
        free_wdata = '{x: '0, y: '0, w: atlas_w, h: atlas_h};
      end
      S_SV_EV: work_we = nonint_rd;
      S_PC_K: begin
        work_we = piece_ok;
        work_wdata = '{dead: 1'b0, box: piece};
      end
      S_PJ_EV: begin
        work_we = drop;
        work_waddr = pi[WORK_AW-1:0];
        work_wdata = '{dead: 1'b1, box: wi};
      end
      S_CP_EV: begin
        free_we = !work_rd_a.dead;
        free_waddr = m[FREE_AW-1:0];
      end
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;
  assign res_load = (state == S_DONE) && res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      free_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pw <= {1'b0, item.rect_width} + {7'b0, pad, 1'b0};
            ph <= {1'b0, item.rect_height} + {7'b0, pad, 1'b0};
            if (item.new_atlas) begin
              free_count <= FCNT_W'(1);
            end
            fi <= '0;
            found <= 1'b0;
            state <= S_FT_RD;
          end
        end
        S_FT_RD: begin
          if (fi == free_count) begin
            fi <= '0;
            wn <= '0;
            if (found) begin
              state <= S_SV_RD;
            end else begin
              res <= '{status: ST_NOFIT, pos_x: '0, pos_y: '0};
              state <= S_DONE;
            end
          end else begin
            state <= S_FT_EV;
          end
        end
        S_FT_EV: begin
          if (fits && (!found || cs < best_s || (cs == best_s && cl < best_l))) begin
            found <= 1'b1;
            best_s <= cs;
            best_l <= cl;
            bx <= free_rd.x;
            by <= free_rd.y;
          end
          fi <= fi + 1'b1;
          state <= S_FT_RD;
        end
        S_SV_RD: begin
          if (fi == free_count) begin
            fi <= '0;
            state <= S_PC_RD;
          end else begin
            state <= S_SV_EV;
          end
        end
        S_SV_EV: begin
          if (nonint_rd) begin
            wn <= wn + 1'b1;
          end
          fi <= fi + 1'b1;
          state <= S_SV_RD;
        end
        S_PC_RD: begin
          if (fi == free_count) begin
            pi <= '0;
            drops <= '0;
            state <= S_PI_RD;
          end else begin
            state <= S_PC_LD;
          end
        end
        S_PC_LD: begin
          fcur <= free_rd;
          k <= '0;
          if (nonint_rd) begin
            fi <= fi + 1'b1;
            state <= S_PC_RD;
          end else begin
            state <= S_PC_K;
          end
        end
        S_PC_K: begin
          if (piece_ok) begin
            wn <= wn + 1'b1;
          end
          k <= k + 1'b1;
          if (k == 2'd3) begin
            fi <= fi + 1'b1;
            state <= S_PC_RD;
          end
        end
        S_PI_RD: begin
          if (pi == wn) begin
            state <= S_CP_CK;
          end else begin
            state <= S_PI_LD;
          end
        end
        S_PI_LD: begin
          wi <= work_rd_a.box;
          pj <= '0;
          state <= S_PJ_RD;
        end
        S_PJ_RD: begin
          if (pj == wn) begin
            pi <= pi + 1'b1;
            state <= S_PI_RD;
          end else begin
            state <= S_PJ_EV;
          end
        end
        S_PJ_EV: begin
          if (drop) begin
            drops <= drops + 1'b1;
            pi <= pi + 1'b1;
            state <= S_PI_RD;
          end else begin
            pj <= pj + 1'b1;
            state <= S_PJ_RD;
          end
        end
        S_CP_CK: begin
          pi <= '0;
          m <= '0;
          if ((wn - drops) > WCNT_W'(MAX_FREE)) begin
            res <= '{status: ST_OVERFLOW, pos_x: '0, pos_y: '0};
            state <= S_DONE;
          end else begin
            state <= S_CP_RD;
          end
        end
        S_CP_RD: begin
          if (pi == wn) begin
            free_count <= m;
            res <= '{status: ST_PLACED, pos_x: bx + {7'b0, pad},
                     pos_y: by + {7'b0, pad}};
            state <= S_DONE;
          end else begin
            state <= S_CP_EV;
          end
        end
        S_CP_EV: begin
          if (!work_rd_a.dead) begin
            m <= m + 1'b1;
          end
          pi <= pi + 1'b1;
          state <= S_CP_RD;
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= FCNT_W'(MAX_FREE))
    else $error("free count above table size");

  a_drops_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PI_RD || state == S_CP_CK) |-> (drops <= pi && pi <= wn))
    else $error("prune counters out of order");

  a_nofit_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_FT_RD && fi == free_count && !found) |=> $stable(free_count))
    else $error("free list changed without a fit");

  a_work_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PC_K) |-> (wn < WCNT_W'(WORK_DEPTH)))
    else $error("work list overrun");

endmodule

// ----- rtl/core/maxrects_bssf_rect_placer.sv -----
// Places one rectangle per transfer; the block is busy until its result is loaded.
// Steps with F free entries and N work entries (N <= 5F): a fit scan and survivor pass
// over the free list, splitting, pruning through the dual-read work memory, and the copy
// back; the next item is taken only once the previous result has been loaded.
// Synchronous active-high reset empties the free list and loads the 1024 by 1024 atlas
// with zero padding; the free-list memory itself is not cleared.
module maxrects_bssf_rect_placer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  maxr_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output maxr_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [14:0]     cfg_data
);
  import maxr_pkg::*;

  coord_t atlas_w, atlas_h;
  logic [7:0] pad;
  logic busy, res_load, res_free;
  out_t res;

  assign in_stall = busy;
  assign res_free = !out_valid || !out_stall;

  maxr_seq u_seq (
    .clk(clk), .rst(rst), .start(in_valid && !busy), .item(in_data),
    .atlas_w(atlas_w), .atlas_h(atlas_h), .pad(pad), .res_free(res_free),
    .busy(busy), .res_load(res_load), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_w <= coord_t'(1024);
      atlas_h <= coord_t'(1024);
      pad <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ATLAS_W: atlas_w <= cfg_data;
          REG_ATLAS_H: atlas_h <= cfg_data;
          REG_PADDING: pad <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res;
    end
  end

endmodule

// ----- test/tb_maxrects_bssf_rect_placer.sv -----
module tb_maxrects_bssf_rect_placer;
  timeunit 1ns;
  timeprecision 1ps;
  import maxr_pkg::*;

  typedef struct {
    int unsigned x;
    int unsigned y;
    int unsigned w;
    int unsigned h;
  } area_t;

  class placement_board;
    area_t       free_list[$];
    int unsigned atlas_w;
    int unsigned atlas_h;
    int unsigned pad;
    out_t        pending_q[$];
    int          errors;

    function new();
      atlas_w = 1024;
      atlas_h = 1024;
      pad = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        REG_ATLAS_W: atlas_w = val;
        REG_ATLAS_H: atlas_h = val;
        REG_PADDING: pad = val[7:0];
        default: ;
      endcase
    endfunction

    function bit contains(area_t a, area_t b);
      return a.x >= b.x && a.y >= b.y && a.x + a.w <= b.x + b.w && a.y + a.h <= b.y + b.h;
    endfunction

    function void note_input(in_t item);
      int unsigned pw, ph, bx, by, bs, bl, dw, dh, s, l;
      bit          found;
      area_t       f, b;
      area_t       kept[$];
      area_t       cut[$];
      int          i, j;
      bit          drop;
      out_t        r;
      r = '0;
      found = 0;
      bx = 0;
      by = 0;
      bs = 0;
      bl = 0;
      if (item.new_atlas) begin
        free_list.delete();
        f.x = 0;
        f.y = 0;
        f.w = atlas_w;
        f.h = atlas_h;
        free_list = {free_list, f};
      end
      pw = item.rect_width + 2 * pad;
      ph = item.rect_height + 2 * pad;
      foreach (free_list[k]) begin
        f = free_list[k];
        if (pw <= f.w && ph <= f.h) begin
          dw = f.w - pw;
          dh = f.h - ph;
          s = dw < dh ? dw : dh;
          l = dw < dh ? dh : dw;
          if (!found || s < bs || (s == bs && l < bl)) begin
            found = 1;
            bs = s;
            bl = l;
            bx = f.x;
            by = f.y;
          end
        end
      end
      if (!found) begin
        r.status = ST_NOFIT;
        pending_q = {pending_q, r};
        return;
      end
      foreach (free_list[k]) begin
        f = free_list[k];
        if (bx >= f.x + f.w || bx + pw <= f.x || by >= f.y + f.h || by + ph <= f.y) begin
          kept = {kept, f};
          continue;
        end
        if (bx > f.x) begin
          b = '{f.x, f.y, bx - f.x, f.h};
          cut = {cut, b};
        end
        if (bx + pw < f.x + f.w) begin
          b = '{bx + pw, f.y, f.x + f.w - bx - pw, f.h};
          cut = {cut, b};
        end
        if (by > f.y) begin
          b = '{f.x, f.y, f.w, by - f.y};
          cut = {cut, b};
        end
        if (by + ph < f.y + f.h) begin
          b = '{f.x, by + ph, f.w, f.y + f.h - by - ph};
          cut = {cut, b};
        end
      end
      kept = {kept, cut};
      i = 0;
      while (i < kept.size()) begin
        drop = 0;
        for (j = 0; j < kept.size(); j++) begin
          if (j != i && contains(kept[i], kept[j])) begin
            drop = 1;
            break;
          end
        end
        if (drop) kept.delete(i);
        else i++;
      end
      if (kept.size() > MAX_FREE) begin
        r.status = ST_OVERFLOW;
      end else begin
        free_list = kept;
        r.status = ST_PLACED;
        r.pos_x = 15'(bx + pad);
        r.pos_y = 15'(by + pad);
      end
      pending_q = {pending_q, r};
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.status !== exp.status)
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
      if (got.pos_x !== exp.pos_x)
        $display("%0t: pos_x expected %0d actual %0d", $time, exp.pos_x, got.pos_x);
      if (got.pos_y !== exp.pos_y)
        $display("%0t: pos_y expected %0d actual %0d", $time, exp.pos_y, got.pos_y);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [14:0] cfg_data;

  placement_board board;
  int accepted;
  int burst_left;

  maxrects_bssf_rect_placer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  clocking cb @(posedge clk);
    input rst, in_stall, out_valid, out_stall, out_data;
  endclocking

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 100000000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_rect(bit na, int unsigned w, int unsigned h);
    in_t item;
    int gap;
    item.new_atlas = na;
    item.rect_width = w[14:0];
    item.rect_height = h[14:0];
    @(negedge clk);
    in_valid = 1;
    in_data = item;
    do @(cb); while (cb.in_stall);
    board.note_input(item);
    accepted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int mode;
    int hold_done;
    int n;
    out_stall = 0;
    hold_done = 0;
    mode = 0;
    n = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && accepted >= 60) begin
        hold_done = 1;
        out_stall = 1;
        repeat (3000) @(negedge clk);
      end
      if (n == 0) begin
        mode = $urandom_range(0, 2);
        n = $urandom_range(20, 80);
      end
      n--;
      case (mode)
        0: out_stall = 0;
        1: out_stall = ~out_stall;
        default: out_stall = ($urandom_range(0, 9) < 4);
      endcase
    end
  end

  always @(cb) begin
    if (!cb.rst && cb.out_valid && !cb.out_stall) board.check_result(cb.out_data);
  end

  initial begin
    int unsigned aw, ah, p, w, h;
    board = new();
    accepted = 0;
    burst_left = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = REG_ATLAS_W;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_rect(0, 10, 10);
    send_rect(1, 100, 200);
    send_rect(0, 0, 0);
    send_rect(0, 1024, 1);
    send_rect(0, 2000, 5);
    send_rect(0, 924, 824);
    send_rect(0, 32767, 32767);
    send_rect(0, 16384, 1);
    send_rect(1, 1024, 1024);
    send_rect(0, 1, 1);
    drain();

    write_reg(REG_ATLAS_W, 1);
    write_reg(REG_ATLAS_H, 1);
    write_reg(REG_PADDING, 0);
    send_rect(1, 1, 1);
    send_rect(0, 0, 0);
    send_rect(1, 0, 1);
    send_rect(1, 2, 1);
    drain();

    write_reg(REG_ATLAS_W, 15'h7fff);
    write_reg(REG_ATLAS_H, 15'h7fff);
    write_reg(REG_PADDING, 255);
    send_rect(1, 16384, 16384);
    send_rect(0, 21845, 10922);
    send_rect(0, 10922, 21845);
    send_rect(0, 32767, 0);
    send_rect(1, 32257, 32257);
    send_rect(1, 32258, 1);
    drain();

    write_reg(REG_ATLAS_W, 0);
    write_reg(REG_ATLAS_H, 300);
    write_reg(REG_PADDING, 0);
    send_rect(1, 0, 5);
    send_rect(1, 1, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      aw = $urandom_range(32, 600);
      ah = $urandom_range(32, 600);
      p = (ph == 4) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      write_reg(REG_ATLAS_W, aw[14:0]);
      write_reg(REG_ATLAS_H, ah[14:0]);
      write_reg(REG_PADDING, p[7:0]);
      for (int s = 0; s < 4; s++) begin
        for (int k = 0; k < 7; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(0, 32767);
            h = $urandom_range(0, 32767);
          end else begin
            w = $urandom_range(0, aw / 3);
            h = $urandom_range(0, ah / 3);
          end
          send_rect(k == 0 || $urandom_range(0, 19) == 0, w, h);
        end
      end
      drain();
    end

    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
